### design/pcht_pkg.sv
`default_nettype none

package pcht_pkg;

  localparam int unsigned DEF_BUCKETS = 128;
  localparam int unsigned DEF_WAYS    = 4;

  // Multiplicative hash constant, close to 2^32 divided by the golden ratio.
  localparam logic [31:0] HASH_MUL = 32'd2654435761;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_DUPLICATE = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP
  } state_t;

  typedef struct packed {
    logic signed [31:0] ctl_handle;
    logic signed [31:0] tx_shm_handle;
    logic signed [31:0] rx_shm_handle;
    logic signed [31:0] tx_ntfn_handle;
    logic signed [31:0] rx_ntfn_handle;
    logic        [31:0] tx_ring_addr;
    logic        [31:0] rx_ring_addr;
  } slot_data_t;

endpackage

`default_nettype wire

### design/pcht_if.sv
`default_nettype none

interface pcht_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  func;
  logic        [31:0] port;
  logic signed [31:0] ctl_handle;
  logic signed [31:0] tx_shm_handle;
  logic signed [31:0] rx_shm_handle;
  logic signed [31:0] tx_ntfn_handle;
  logic signed [31:0] rx_ntfn_handle;
  logic        [31:0] tx_ring_addr;
  logic        [31:0] rx_ring_addr;

  modport source (
    output valid, func, port, ctl_handle, tx_shm_handle, rx_shm_handle,
           tx_ntfn_handle, rx_ntfn_handle, tx_ring_addr, rx_ring_addr,
    input  ready
  );
  modport sink (
    input  valid, func, port, ctl_handle, tx_shm_handle, rx_shm_handle,
           tx_ntfn_handle, rx_ntfn_handle, tx_ring_addr, rx_ring_addr,
    output ready
  );
endinterface

interface pcht_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] out_ctl_handle;
  logic signed [31:0] out_tx_shm_handle;
  logic signed [31:0] out_rx_shm_handle;
  logic signed [31:0] out_tx_ntfn_handle;
  logic signed [31:0] out_rx_ntfn_handle;
  logic        [31:0] out_tx_ring_addr;
  logic        [31:0] out_rx_ring_addr;

  modport source (
    output valid, status, out_ctl_handle, out_tx_shm_handle, out_rx_shm_handle,
           out_tx_ntfn_handle, out_rx_ntfn_handle, out_tx_ring_addr,
           out_rx_ring_addr,
    input  ready
  );
  modport sink (
    input  valid, status, out_ctl_handle, out_tx_shm_handle, out_rx_shm_handle,
           out_tx_ntfn_handle, out_rx_ntfn_handle, out_tx_ring_addr,
           out_rx_ring_addr,
    output ready
  );
endinterface

`default_nettype wire

### design/port_connection_hash_table_core.sv
`default_nettype none

// Connection table keyed by a 32-bit port, held as BUCKETS rows of WAYS
// slots in two registered-read memories: a tag row (valid bits and
// ports) and a data row (the seven stored words). The bucket is the top
// bits of port * 2654435761 mod 2^32, scaled by BUCKETS. For every
// operation the hash multiply is registered on the accepting beat,
// the bucket row is read in the next cycle, and in the compare state the ways are
// compared, the row is written back and the result is registered. A new
// beat is taken in the cycle after that, so the block takes no new item
// until the last one is through this read-compare-write loop on the row
// memories. A result left waiting on the output holds the compare stage.
// After reset a clearing pass zeroes the valid bits row by row; no item
// is accepted until it has finished.
module port_connection_hash_table_core
  import pcht_pkg::*;
#(
  parameter int unsigned BUCKETS = DEF_BUCKETS,
  parameter int unsigned WAYS    = DEF_WAYS
) (
  input  wire        clk,
  input  wire        rst_n,
  pcht_in_if.sink    in_chan,
  pcht_out_if.source out_chan
);

  localparam int unsigned BKT_W = $clog2(BUCKETS);
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned PRD_W = 32 + BKT_W;
  localparam logic [PRD_W-1:0] BUCKETS_L = PRD_W'(BUCKETS);
  localparam logic [BKT_W-1:0] LAST_BKT  = BKT_W'(BUCKETS - 1);

  typedef struct packed {
    logic [WAYS-1:0]       valid;
    logic [WAYS-1:0][31:0] port;
  } tag_row_t;

  typedef slot_data_t [WAYS-1:0] data_row_t;

  // Row memories.
  tag_row_t  tag_mem  [BUCKETS];
  data_row_t data_mem [BUCKETS];

  state_t           state_r, state_nxt;
  logic [BKT_W-1:0] clr_cnt_r;

  logic [1:0]       func_r;
  logic [31:0]      port_r;
  slot_data_t       wdata_r;
  logic [31:0]      hash_r;
  logic [BKT_W-1:0] bkt_r;

  tag_row_t  tag_rd_r;
  data_row_t data_rd_r;

  logic [PRD_W-1:0] bkt_prod;
  logic [BKT_W-1:0] bkt_sel;

  logic             in_fire;
  logic             rd_en;
  logic             advance;
  logic             tag_we;
  logic             data_we;
  logic [BKT_W-1:0] waddr;
  tag_row_t         tag_wdata;
  data_row_t        data_wdata;

  logic [WAYS-1:0]  hit_vec;
  logic [WAYS-1:0]  free_vec;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;
  logic             hit_any;
  logic             free_any;
  tag_row_t         tag_mod;
  data_row_t        data_mod;
  logic             cmp_tag_we;
  logic             cmp_data_we;
  status_t          cmp_status;
  slot_data_t       cmp_data;

  logic             out_valid_r;
  status_t          out_status_r;
  slot_data_t       out_data_r;

  assign bkt_prod = {{BKT_W{1'b0}}, hash_r} * BUCKETS_L;
  assign bkt_sel  = bkt_prod[PRD_W-1:32];

  assign in_fire = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_chan.ready  = 1'b0;
    rd_en          = 1'b0;
    advance        = 1'b0;
    tag_we         = 1'b0;
    data_we        = 1'b0;
    waddr          = bkt_r;
    tag_wdata      = tag_mod;
    data_wdata     = data_mod;
    unique case (state_r)
      S_CLEAR: begin
        tag_we    = 1'b1;
        waddr     = clr_cnt_r;
        tag_wdata = '0;
        if (clr_cnt_r == LAST_BKT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!out_valid_r || out_chan.ready) begin
          advance   = 1'b1;
          tag_we    = cmp_tag_we;
          data_we   = cmp_data_we;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Input payload, hash and bucket registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r                 <= in_chan.func;
      port_r                 <= in_chan.port;
      hash_r                 <= 32'(in_chan.port * HASH_MUL);
      wdata_r.ctl_handle     <= in_chan.ctl_handle;
      wdata_r.tx_shm_handle  <= in_chan.tx_shm_handle;
      wdata_r.rx_shm_handle  <= in_chan.rx_shm_handle;
      wdata_r.tx_ntfn_handle <= in_chan.tx_ntfn_handle;
      wdata_r.rx_ntfn_handle <= in_chan.rx_ntfn_handle;
      wdata_r.tx_ring_addr   <= in_chan.tx_ring_addr;
      wdata_r.rx_ring_addr   <= in_chan.rx_ring_addr;
    end
    if (rd_en) begin
      bkt_r <= bkt_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[waddr] <= tag_wdata;
    end
    if (data_we) begin
      data_mem[waddr] <= data_wdata;
    end
    if (rd_en) begin
      tag_rd_r  <= tag_mem[bkt_sel];
      data_rd_r <= data_mem[bkt_sel];
    end
  end

  // Way compare and row update.
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      hit_vec[w]  = tag_rd_r.valid[w] && (tag_rd_r.port[w] == port_r);
      free_vec[w] = !tag_rd_r.valid[w];
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_way = WAY_W'(w);
      end
    end
    hit_any  = |hit_vec;
    free_any = |free_vec;

    tag_mod     = tag_rd_r;
    data_mod    = data_rd_r;
    cmp_tag_we  = 1'b0;
    cmp_data_we = 1'b0;
    cmp_status  = STAT_NOT_FOUND;
    cmp_data    = '0;

    priority if (func_r == FUNC_LOOKUP) begin
      if (hit_any) begin
        cmp_status = STAT_OK;
        cmp_data   = data_rd_r[hit_way];
      end
    end else if (func_r == FUNC_INSERT) begin
      if (hit_any) begin
        cmp_status = STAT_DUPLICATE;
      end else if (!free_any) begin
        cmp_status = STAT_FULL;
      end else begin
        cmp_status              = STAT_OK;
        tag_mod.valid[free_way] = 1'b1;
        tag_mod.port[free_way]  = port_r;
        data_mod[free_way]      = wdata_r;
        cmp_tag_we              = 1'b1;
        cmp_data_we             = 1'b1;
      end
    end else if (func_r == FUNC_REMOVE) begin
      if (hit_any) begin
        cmp_status             = STAT_OK;
        tag_mod.valid[hit_way] = 1'b0;
        cmp_tag_we             = 1'b1;
      end
    end else begin
      // The spare operation code leaves the table alone.
      cmp_status = STAT_NOT_FOUND;
    end
  end

  // Output register: a finished beat waits here while the next item enters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= cmp_status;
      out_data_r   <= cmp_data;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.status             = out_status_r;
  assign out_chan.out_ctl_handle     = out_data_r.ctl_handle;
  assign out_chan.out_tx_shm_handle  = out_data_r.tx_shm_handle;
  assign out_chan.out_rx_shm_handle  = out_data_r.rx_shm_handle;
  assign out_chan.out_tx_ntfn_handle = out_data_r.tx_ntfn_handle;
  assign out_chan.out_rx_ntfn_handle = out_data_r.rx_ntfn_handle;
  assign out_chan.out_tx_ring_addr   = out_data_r.tx_ring_addr;
  assign out_chan.out_rx_ring_addr   = out_data_r.rx_ring_addr;

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import pcht_pkg::*;
;

  localparam int unsigned SLOTS = DEF_BUCKETS * DEF_WAYS;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned RANDOM_OPS = 800;
  localparam int unsigned IDLE_PCT = 28;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] port;
    slot_data_t  data;
  } table_op_t;

  typedef struct packed {
    status_t    status;
    slot_data_t data;
  } table_result_t;

  typedef struct packed {
    table_op_t op;
    logic      fixed;
    status_t   fixed_status;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic steady = 1'b0;
  int   mismatch_count = 0;

  pcht_in_if  in_chan ();
  pcht_out_if out_chan ();

  port_connection_hash_table_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow copy of the connection table.
  bit            shadow_valid [SLOTS];
  logic [31:0]   shadow_port  [SLOTS];
  slot_data_t    shadow_data  [SLOTS];
  table_result_t pending_results [$];

  directed_row_t directed_rows [$];
  logic [31:0]   bucket_mates [$];
  logic [31:0]   hot_ports [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned bucket_of_port(input logic [31:0] port);
    logic [31:0] hashed;
    logic [63:0] scaled;
    hashed = port * HASH_MUL;
    scaled = {32'd0, hashed} * 64'(DEF_BUCKETS);
    return scaled[63:32];
  endfunction

  function automatic table_result_t apply_table_op(input table_op_t op);
    table_result_t res;
    int unsigned   base;
    int            hit;
    int            free_slot;
    base = bucket_of_port(op.port) * DEF_WAYS;
    hit = -1;
    free_slot = -1;
    for (int w = 0; w < DEF_WAYS; w++) begin
      if (shadow_valid[base + w] && shadow_port[base + w] == op.port && hit < 0) begin
        hit = base + w;
      end
      if (!shadow_valid[base + w] && free_slot < 0) begin
        free_slot = base + w;
      end
    end
    res.status = STAT_NOT_FOUND;
    res.data = '0;
    case (op.func)
      FUNC_LOOKUP: begin
        if (hit >= 0) begin
          res.status = STAT_OK;
          res.data = shadow_data[hit];
        end
      end
      FUNC_INSERT: begin
        if (hit >= 0) begin
          res.status = STAT_DUPLICATE;
        end else if (free_slot < 0) begin
          res.status = STAT_FULL;
        end else begin
          shadow_valid[free_slot] = 1'b1;
          shadow_port[free_slot] = op.port;
          shadow_data[free_slot] = op.data;
          res.status = STAT_OK;
        end
      end
      FUNC_REMOVE: begin
        if (hit >= 0) begin
          shadow_valid[hit] = 1'b0;
          res.status = STAT_OK;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic slot_data_t random_data();
    slot_data_t d;
    d.ctl_handle = $urandom;
    d.tx_shm_handle = $urandom;
    d.rx_shm_handle = $urandom;
    d.tx_ntfn_handle = $urandom;
    d.rx_ntfn_handle = $urandom;
    d.tx_ring_addr = $urandom;
    d.rx_ring_addr = $urandom;
    return d;
  endfunction

  task automatic add_row(input logic [1:0] func, input logic [31:0] port,
                         input slot_data_t data, input logic fixed,
                         input status_t fixed_status);
    directed_row_t row;
    row.op.func = func;
    row.op.port = port;
    row.op.data = data;
    row.fixed = fixed;
    row.fixed_status = fixed_status;
    directed_rows.push_back(row);
  endtask

  // Drives one beat, with a random run of idle cycles in front of it unless
  // the steady stretch is on, and returns once the block has taken it.
  task automatic send_beat(input table_op_t op);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.func <= op.func;
    in_chan.port <= op.port;
    in_chan.ctl_handle <= op.data.ctl_handle;
    in_chan.tx_shm_handle <= op.data.tx_shm_handle;
    in_chan.rx_shm_handle <= op.data.rx_shm_handle;
    in_chan.tx_ntfn_handle <= op.data.tx_ntfn_handle;
    in_chan.rx_ntfn_handle <= op.data.rx_ntfn_handle;
    in_chan.tx_ring_addr <= op.data.tx_ring_addr;
    in_chan.rx_ring_addr <= op.data.rx_ring_addr;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic drain_pending();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    table_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with nothing expected, status %h", $time,
               out_chan.status);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("status", 32'(want.status), 32'(out_chan.status));
      compare_field("ctl_handle", want.data.ctl_handle, out_chan.out_ctl_handle);
      compare_field("tx_shm_handle", want.data.tx_shm_handle, out_chan.out_tx_shm_handle);
      compare_field("rx_shm_handle", want.data.rx_shm_handle, out_chan.out_rx_shm_handle);
      compare_field("tx_ntfn_handle", want.data.tx_ntfn_handle,
                    out_chan.out_tx_ntfn_handle);
      compare_field("rx_ntfn_handle", want.data.rx_ntfn_handle,
                    out_chan.out_rx_ntfn_handle);
      compare_field("tx_ring_addr", want.data.tx_ring_addr, out_chan.out_tx_ring_addr);
      compare_field("rx_ring_addr", want.data.rx_ring_addr, out_chan.out_rx_ring_addr);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      check_result();
    end
    out_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    slot_data_t    data_min;
    slot_data_t    data_max;
    table_op_t     op;
    table_result_t got;
    logic [31:0]   probe;
    int unsigned   pick;

    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.func = FUNC_LOOKUP;
    in_chan.port = '0;
    in_chan.ctl_handle = '0;
    in_chan.tx_shm_handle = '0;
    in_chan.rx_shm_handle = '0;
    in_chan.tx_ntfn_handle = '0;
    in_chan.rx_ntfn_handle = '0;
    in_chan.tx_ring_addr = '0;
    in_chan.rx_ring_addr = '0;
    out_chan.ready = 1'b0;
    for (int s = 0; s < SLOTS; s++) shadow_valid[s] = 1'b0;

    data_min = {{5{32'h8000_0000}}, 32'h0, 32'h0};
    data_max = {{5{32'h7FFF_FFFF}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF};

    // Four further ports that share bucket 0 with port zero.
    probe = 32'd1;
    while (bucket_mates.size() < 4) begin
      if (bucket_of_port(probe) == 0) bucket_mates.push_back(probe);
      probe++;
    end

    add_row(FUNC_LOOKUP, 32'h0, data_max, 1'b1, STAT_NOT_FOUND);
    add_row(FUNC_REMOVE, 32'hFFFF_FFFF, data_max, 1'b1, STAT_NOT_FOUND);
    add_row(FUNC_UNUSED, 32'h0, data_max, 1'b1, STAT_NOT_FOUND);
    add_row(FUNC_INSERT, 32'h0, data_min, 1'b1, STAT_OK);
    add_row(FUNC_INSERT, 32'h0, data_max, 1'b1, STAT_DUPLICATE);
    add_row(FUNC_LOOKUP, 32'h0, random_data(), 1'b0, STAT_OK);
    add_row(FUNC_INSERT, bucket_mates[0], data_max, 1'b1, STAT_OK);
    add_row(FUNC_INSERT, bucket_mates[1], random_data(), 1'b1, STAT_OK);
    add_row(FUNC_INSERT, bucket_mates[2], random_data(), 1'b1, STAT_OK);
    add_row(FUNC_INSERT, bucket_mates[3], random_data(), 1'b1, STAT_FULL);
    add_row(FUNC_LOOKUP, bucket_mates[3], random_data(), 1'b1, STAT_NOT_FOUND);
    add_row(FUNC_LOOKUP, bucket_mates[2], random_data(), 1'b0, STAT_OK);
    add_row(FUNC_REMOVE, bucket_mates[0], random_data(), 1'b1, STAT_OK);
    add_row(FUNC_LOOKUP, bucket_mates[0], random_data(), 1'b1, STAT_NOT_FOUND);
    add_row(FUNC_INSERT, bucket_mates[3], random_data(), 1'b1, STAT_OK);
    add_row(FUNC_LOOKUP, bucket_mates[3], random_data(), 1'b0, STAT_OK);
    add_row(FUNC_REMOVE, bucket_mates[0], random_data(), 1'b1, STAT_NOT_FOUND);
    add_row(FUNC_INSERT, 32'hFFFF_FFFF, data_max, 1'b1, STAT_OK);
    add_row(FUNC_LOOKUP, 32'hFFFF_FFFF, random_data(), 1'b0, STAT_OK);
    add_row(FUNC_UNUSED, 32'hFFFF_FFFF, data_min, 1'b1, STAT_NOT_FOUND);
    add_row(FUNC_REMOVE, 32'h0, random_data(), 1'b1, STAT_OK);
    add_row(FUNC_LOOKUP, 32'h0, random_data(), 1'b1, STAT_NOT_FOUND);
    add_row(FUNC_LOOKUP, bucket_mates[1], random_data(), 1'b0, STAT_OK);

    // Most random traffic goes to a few crowded buckets so that duplicates,
    // full buckets and hits on earlier inserts are common.
    hot_ports.push_back(32'h0);
    hot_ports.push_back(32'hFFFF_FFFF);
    foreach (bucket_mates[i]) hot_ports.push_back(bucket_mates[i]);
    while (hot_ports.size() < 46) begin
      probe = $urandom;
      if (bucket_of_port(probe) < 8) hot_ports.push_back(probe);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].op);
      got = apply_table_op(directed_rows[i].op);
      if (directed_rows[i].fixed) begin
        got.status = directed_rows[i].fixed_status;
        got.data = '0;
      end
      pending_results.push_back(got);
    end
    drain_pending();

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == 300) steady <= 1'b1;
      if (n == 450) steady <= 1'b0;
      if (n == 400) drain_pending();
      pick = $urandom_range(99);
      if (pick < 5) begin
        op.func = FUNC_UNUSED;
      end else if (pick < 40) begin
        op.func = FUNC_LOOKUP;
      end else if (pick < 75) begin
        op.func = FUNC_INSERT;
      end else begin
        op.func = FUNC_REMOVE;
      end
      if ($urandom_range(99) < 75) begin
        op.port = hot_ports[$urandom_range(hot_ports.size() - 1)];
      end else begin
        op.port = $urandom;
      end
      op.data = random_data();
      send_beat(op);
      pending_results.push_back(apply_table_op(op));
    end

    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### port_connection_hash_table_core.f
design/pcht_pkg.sv
design/pcht_if.sv
design/port_connection_hash_table_core.sv
test/tb_top.sv
